FILE: hdl/assert_macros.svh
// Assertion macros shared by the page bitmap allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: hdl/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
// No dependencies; used by pba_addr_div and page_bitmap_allocator_top.
package pba_pkg;

    // Default geometry
    localparam int MAP_WORDS_DEF  = 512;
    localparam int PAGE_BYTES_DEF = 4096;

    // Field widths
    localparam int ADDR_W   = 24;
    localparam int BYTES_W  = 25;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 80;
    localparam int M_PAD_W   = M_TDATA_W - ADDR_W - 2 * BYTES_W;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

    // Map word with every page in use
    localparam logic [7:0] FULL_WORD = 8'hFF;

    // Page number result from the address converter
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] page;
    } div_res_t;

endpackage

FILE: hdl/pba_addr_div.sv
// Byte address to page number converter (address / PAGE_BYTES, rounded down).
// Depends on pba_pkg. Three-stage reciprocal multiply with one-step correction.
module pba_addr_div #(
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pba_pkg::ADDR_W-1:0]  addr,
    output pba_pkg::div_res_t           res
);

    localparam int RSH  = 39;
    localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / PAGE_BYTES);
    localparam logic [16:0] PB    = 17'(PAGE_BYTES);
    localparam int MAXQ = ((1 << pba_pkg::ADDR_W) - 1) / PAGE_BYTES;
    localparam int QW   = $clog2(MAXQ + 1);
    localparam int PW   = pba_pkg::ADDR_W + 32;
    localparam int MW   = QW + 17;

    logic                        s1_vld_reg;
    logic                        s2_vld_reg;
    logic                        done_reg;
    logic [pba_pkg::ADDR_W-1:0]  addr_reg;
    logic [PW-1:0]               prod_reg;
    logic [QW-1:0]               q0_reg;
    logic [pba_pkg::ADDR_W-1:0]  back_reg;
    logic [QW-1:0]               q_reg;

    logic [QW-1:0]               q0;
    logic [MW-1:0]               back;
    logic [pba_pkg::ADDR_W-1:0]  rem;

    // Estimate is low by at most one; the remainder check fixes it
    assign q0   = prod_reg[RSH +: QW];
    assign back = MW'(q0) * MW'(PB);
    assign rem  = addr_reg - back_reg;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg <= addr;
            prod_reg <= PW'(addr) * PW'(RECIP);
        end
        if (s1_vld_reg)
        begin
            q0_reg   <= q0;
            back_reg <= pba_pkg::ADDR_W'(back);
        end
        if (s2_vld_reg)
        begin
            q_reg <= (32'(rem) >= 32'(PAGE_BYTES)) ? q0_reg + QW'(1) : q0_reg;
        end
    end

    assign res.done = done_reg;
    assign res.page = pba_pkg::ADDR_W'(q_reg);

endmodule

FILE: hdl/page_bitmap_allocator_top.sv
// Page bitmap allocator: allocate lowest free page or free a page by address.
// Allocate: scan from the first map word that is not full, set its lowest clear bit, form the address.
// Free: the address converter gives the page number, then a map read, then the bit is cleared.
// One item at a time; the next item is taken while the result waits to be taken.
// Reset clears control at once; map words are tracked by a fill count, no sweep.
module page_bitmap_allocator_top #(
    parameter int MAP_WORDS  = pba_pkg::MAP_WORDS_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pba_pkg::S_TDATA_W-1:0]  s_tdata,   // [23:0] page_addr
    input  logic                           s_tuser,   // [0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pba_pkg::M_TDATA_W-1:0]  m_tdata,   // [23:0] alloc_addr, [48:24] used_bytes,
                                                      // [73:49] free_bytes, [79:74] zero
    output logic [pba_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);

    `include "assert_macros.svh"

    localparam int WW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PTR_W  = $clog2(MAP_WORDS + 1);
    localparam int PAGE_W = PTR_W + 3;
    localparam int AM_W   = PAGE_W + 17;
    localparam logic [63:0] POOL_PAGES = 64'(MAP_WORDS) * 64'd8;
    localparam logic [63:0] POOL_BYTES = POOL_PAGES * 64'(PAGE_BYTES);
    localparam int UW     = $clog2(POOL_BYTES + 64'd1);
    localparam logic [16:0]      PB       = 17'(PAGE_BYTES);
    localparam logic [UW-1:0]    PB_U     = UW'(PAGE_BYTES);
    localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(MAP_WORDS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAP_WORDS - 1);

    // Controller states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ARD  = 3'd1;
    localparam logic [2:0] S_AMUL = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_FRD  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [PTR_W-1:0]                ptr_reg, ptr_next;     // all words below are full
    logic [PTR_W-1:0]                hw_reg, hw_next;       // words below have been written
    logic [UW-1:0]                   used_reg, used_next;
    logic [PTR_W-1:0]                fw_reg, fw_next;
    logic [2:0]                      fbit_reg, fbit_next;
    logic [PAGE_W-1:0]               page_reg, page_next;
    logic [pba_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [pba_pkg::ADDR_W-1:0]      res_aaddr_reg, res_aaddr_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [pba_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic [pba_pkg::STATUS_W-1:0]    m_tuser_reg;
    logic                            out_load;

    // Map memory
    logic [7:0]                      map_mem [MAP_WORDS];
    logic [7:0]                      rd_data_reg;
    logic                            rd_en, wr_en;
    logic [WW-1:0]                   rd_addr, wr_addr;
    logic [7:0]                      wr_data;

    logic                            div_start;
    pba_pkg::div_res_t               div_res;

    logic [7:0]                      aword, fword;
    logic [2:0]                      zbit;
    logic [31:0]                     dpage;
    logic [AM_W-1:0]                 amul;
    logic [63:0]                     used64, free64;

    pba_addr_div #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .addr  (s_tdata[pba_pkg::ADDR_W-1:0]),
        .res   (div_res)
    );

    // Words at or past the fill count were never written and read as free
    assign aword = (ptr_reg < hw_reg) ? rd_data_reg : 8'd0;
    assign fword = (fw_reg  < hw_reg) ? rd_data_reg : 8'd0;
    assign dpage = 32'(div_res.page);
    assign amul  = AM_W'(page_reg) * AM_W'(PB);

    // Lowest clear bit of the scanned word
    always_comb
    begin
        zbit = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!aword[i])
                zbit = 3'(i);
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign div_start = s_tvalid && s_tready && (s_tuser == pba_pkg::MODE_FREE);
    assign out_load  = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        hw_next         = hw_reg;
        used_next       = used_reg;
        fw_next         = fw_reg;
        fbit_next       = fbit_reg;
        page_next       = page_reg;
        res_status_next = res_status_reg;
        res_aaddr_next  = res_aaddr_reg;
        rd_en           = 1'b0;
        rd_addr         = WW'(ptr_reg);
        wr_en           = 1'b0;
        wr_addr         = WW'(ptr_reg);
        wr_data         = aword | (8'd1 << zbit);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_aaddr_next = '0;
                    if (s_tuser == pba_pkg::MODE_FREE)
                    begin
                        state_next = S_DIVW;
                    end
                    else if (ptr_reg == PTR_END)
                    begin
                        res_status_next = pba_pkg::ST_OOM;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_ARD;
                    end
                end
            end
            S_ARD:
            begin
                if (aword == pba_pkg::FULL_WORD)
                begin
                    if (ptr_reg == PTR_LAST)
                    begin
                        ptr_next        = PTR_END;
                        res_status_next = pba_pkg::ST_OOM;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + PTR_W'(1);
                        rd_en      = 1'b1;
                        rd_addr    = WW'(ptr_reg + PTR_W'(1));
                    end
                end
                else
                begin
                    wr_en     = 1'b1;
                    used_next = used_reg + PB_U;
                    page_next = {ptr_reg, zbit};
                    if (ptr_reg == hw_reg)
                        hw_next = hw_reg + PTR_W'(1);
                    state_next = S_AMUL;
                end
            end
            S_AMUL:
            begin
                res_aaddr_next  = pba_pkg::ADDR_W'(amul);
                res_status_next = pba_pkg::ST_OK;
                state_next      = S_EMIT;
            end
            S_DIVW:
            begin
                if (div_res.done)
                begin
                    if (dpage >= 32'(POOL_PAGES))
                    begin
                        res_status_next = pba_pkg::ST_RANGE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        fw_next    = PTR_W'(dpage >> 3);
                        fbit_next  = dpage[2:0];
                        rd_en      = 1'b1;
                        rd_addr    = WW'(dpage >> 3);
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                if (!fword[fbit_reg])
                begin
                    res_status_next = pba_pkg::ST_DOUBLE;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = WW'(fw_reg);
                    wr_data = fword & ~(8'd1 << fbit_reg);
                    used_next = (used_reg >= PB_U) ? used_reg - PB_U : '0;
                    if (fw_reg < ptr_reg)
                        ptr_next = fw_reg;
                    res_status_next = pba_pkg::ST_OK;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load)
            m_tvalid_next = 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            hw_reg       <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            hw_reg       <= hw_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    assign used64 = 64'(used_reg);
    assign free64 = POOL_BYTES - used64;

    always_ff @(posedge clk)
    begin
        fw_reg         <= fw_next;
        fbit_reg       <= fbit_next;
        page_reg       <= page_next;
        res_status_reg <= res_status_next;
        res_aaddr_reg  <= res_aaddr_next;
        if (out_load)
        begin
            m_tdata_reg <= {{pba_pkg::M_PAD_W{1'b0}},
                            free64[pba_pkg::BYTES_W-1:0],
                            used64[pba_pkg::BYTES_W-1:0],
                            res_aaddr_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    // Map memory, one read and one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= map_mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `ASSERT_ALWAYS(a_ptr_le_fill, clk, rst_n, (ptr_reg <= hw_reg) && (hw_reg <= PTR_END))
    `ASSERT_ALWAYS(a_used_le_pool, clk, rst_n, 64'(used_reg) <= POOL_BYTES)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready, state_reg != S_IDLE)
    `ASSERT_IMPLIES(a_oom_full, clk, rst_n,
        (state_reg == S_EMIT) && (res_status_reg == pba_pkg::ST_OOM), ptr_reg == PTR_END)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for page_bitmap_allocator_top: directed table, then random traffic with edge frees.
// Depends on pba_pkg (hdl/pba_pkg.sv) and the allocator RTL; expected results come from typed table
// rows or else from a local shadow of the page map and the used-byte count.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_PAGES   = pba_pkg::MAP_WORDS_DEF * 8;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [pba_pkg::BYTES_W-1:0] POOL_BYTES =
        pba_pkg::BYTES_W'(POOL_PAGES * pba_pkg::PAGE_BYTES_DEF);

    // One result item, as carried on m_tdata / m_tuser
    typedef struct packed {
        logic [pba_pkg::STATUS_W-1:0] status;
        logic [pba_pkg::ADDR_W-1:0]   alloc_addr;
        logic [pba_pkg::BYTES_W-1:0]  used_bytes;
        logic [pba_pkg::BYTES_W-1:0]  free_bytes;
    } pool_result_t;

    // Directed stimulus row; the result is only used when typed is set
    typedef struct packed {
        logic                       mode;
        logic [pba_pkg::ADDR_W-1:0] addr;
        bit                         typed;
        pool_result_t               res;
    } dir_row_t;

    typedef enum int {RCV_OPEN, RCV_RANDOM, RCV_PERIODIC} rcv_mode_t;

    localparam pool_result_t NO_RES = '0;

    localparam dir_row_t DIRECTED_ROWS [23] = '{
        // fresh pool: lowest pages first
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b1,
          '{pba_pkg::ST_OK, 24'h000000, 25'd4096, 25'd16773120}},
        '{pba_pkg::MODE_ALLOC, 24'hFFFFFF, 1'b1,
          '{pba_pkg::ST_OK, 24'h001000, 25'd8192, 25'd16769024}},
        '{pba_pkg::MODE_FREE,  24'h000000, 1'b1,
          '{pba_pkg::ST_OK, 24'h000000, 25'd4096, 25'd16773120}},
        // same page again, unaligned address
        '{pba_pkg::MODE_FREE,  24'h000FFF, 1'b1,
          '{pba_pkg::ST_DOUBLE, 24'h000000, 25'd4096, 25'd16773120}},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b1,
          '{pba_pkg::ST_OK, 24'h000000, 25'd8192, 25'd16769024}},
        '{pba_pkg::MODE_FREE,  24'h001FFF, 1'b1,
          '{pba_pkg::ST_OK, 24'h000000, 25'd4096, 25'd16773120}},
        // top page of the pool, never allocated
        '{pba_pkg::MODE_FREE,  24'hFFFFFF, 1'b1,
          '{pba_pkg::ST_DOUBLE, 24'h000000, 25'd4096, 25'd16773120}},
        '{pba_pkg::MODE_FREE,  24'h800000, 1'b0, NO_RES},
        // fill word 0, then step over it
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'hFFFFFF, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h123456, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'hABCDEF, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        // hole in the middle of a word is reused first
        '{pba_pkg::MODE_FREE,  24'h003ABC, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        '{pba_pkg::MODE_FREE,  24'h007000, 1'b0, NO_RES},
        '{pba_pkg::MODE_FREE,  24'h008001, 1'b0, NO_RES},
        '{pba_pkg::MODE_ALLOC, 24'h000000, 1'b0, NO_RES},
        '{pba_pkg::MODE_FREE,  24'h555555, 1'b0, NO_RES},
        '{pba_pkg::MODE_FREE,  24'hAAAAAA, 1'b0, NO_RES}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pba_pkg::S_TDATA_W-1:0]  s_tdata = '0;     // [23:0] page_addr
    logic                           s_tuser = 1'b0;   // [0] mode
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pba_pkg::M_TDATA_W-1:0]  m_tdata;          // [23:0] alloc_addr, [48:24] used_bytes,
                                                      // [73:49] free_bytes, [79:74] zero
    logic [pba_pkg::STATUS_W-1:0]   m_tuser;          // [1:0] status

    // Shadow of the allocator state
    logic [7:0]                     shadow_map [pba_pkg::MAP_WORDS_DEF];
    logic [pba_pkg::BYTES_W-1:0]    shadow_used;
    pool_result_t                   pending_results [$];

    int        fail_count;
    int        cycle_count;
    int        burst_left;
    int        n_alloc, n_free, n_oom, n_double, peak_pages;
    rcv_mode_t rcv_mode;
    int        rcv_left;

    page_bitmap_allocator_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // Apply one request to the shadow state and work out its result
    task automatic track_request(input logic mode, input logic [pba_pkg::ADDR_W-1:0] addr,
                                 output pool_result_t r);
        int unsigned pg;
        int          w;
        int          b;
        bit          found;
        r = '0;
        found = 1'b0;
        if (mode == pba_pkg::MODE_ALLOC)
        begin
            // lowest word with room, then lowest clear bit in it
            for (w = 0; w < pba_pkg::MAP_WORDS_DEF && !found; w++)
            begin
                if (shadow_map[w] != pba_pkg::FULL_WORD)
                begin
                    for (b = 0; b < 8 && !found; b++)
                    begin
                        if (!shadow_map[w][b])
                        begin
                            shadow_map[w][b] = 1'b1;
                            shadow_used += pba_pkg::BYTES_W'(pba_pkg::PAGE_BYTES_DEF);
                            r.alloc_addr =
                                pba_pkg::ADDR_W'((w * 8 + b) * pba_pkg::PAGE_BYTES_DEF);
                            found = 1'b1;
                        end
                    end
                end
            end
            r.status = found ? pba_pkg::ST_OK : pba_pkg::ST_OOM;
        end
        else
        begin
            pg = addr / pba_pkg::PAGE_BYTES_DEF;
            if (pg >= POOL_PAGES)
                r.status = pba_pkg::ST_RANGE;
            else if (!shadow_map[pg / 8][pg % 8])
                r.status = pba_pkg::ST_DOUBLE;
            else
            begin
                shadow_map[pg / 8][pg % 8] = 1'b0;
                if (shadow_used >= pba_pkg::PAGE_BYTES_DEF)
                    shadow_used -= pba_pkg::BYTES_W'(pba_pkg::PAGE_BYTES_DEF);
                else
                    shadow_used = '0;
                r.status = pba_pkg::ST_OK;
            end
        end
        r.used_bytes = shadow_used;
        r.free_bytes = POOL_BYTES - shadow_used;
    endtask

    // Drive one item, wait for it to be taken, queue its expected result
    task automatic send_request(input logic mode, input logic [pba_pkg::ADDR_W-1:0] addr,
                                input bit typed, input pool_result_t typed_res);
        pool_result_t r;
        // end of a burst: drop valid for a random gap
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        track_request(mode, addr, r);
        pending_results.push_back(typed ? typed_res : r);
        if (mode == pba_pkg::MODE_ALLOC)
            n_alloc++;
        else
            n_free++;
        if (r.status == pba_pkg::ST_OOM)
            n_oom++;
        if (r.status == pba_pkg::ST_DOUBLE)
            n_double++;
        if (shadow_used / pba_pkg::PAGE_BYTES_DEF > peak_pages)
            peak_pages = shadow_used / pba_pkg::PAGE_BYTES_DEF;
    endtask

    // Random used page, or -1 when the pool is empty
    function automatic int pick_used_page();
        int start;
        int k;
        int pg;
        start = $urandom_range(0, POOL_PAGES - 1);
        for (k = 0; k < POOL_PAGES; k++)
        begin
            pg = (start + k) % POOL_PAGES;
            if (shadow_map[pg / 8][pg % 8])
                return pg;
        end
        return -1;
    endfunction

    // Mix of allocates, frees of live pages and frees of arbitrary addresses
    task automatic issue_random_request(input int alloc_pct, input int live_free_pct);
        int roll;
        int pg;
        roll = $urandom_range(0, 99);
        pg = pick_used_page();
        if (roll < alloc_pct)
            send_request(pba_pkg::MODE_ALLOC, pba_pkg::ADDR_W'($urandom), 1'b0, NO_RES);
        else if (roll < alloc_pct + live_free_pct && pg >= 0)
            send_request(pba_pkg::MODE_FREE,
                         pba_pkg::ADDR_W'(pg * pba_pkg::PAGE_BYTES_DEF +
                                          $urandom_range(0, pba_pkg::PAGE_BYTES_DEF - 1)),
                         1'b0, NO_RES);
        else
            send_request(pba_pkg::MODE_FREE, pba_pkg::ADDR_W'($urandom), 1'b0, NO_RES);
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin : result_monitor
        pool_result_t got;
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tuser;
            got.alloc_addr = m_tdata[pba_pkg::ADDR_W-1:0];
            got.used_bytes = m_tdata[pba_pkg::ADDR_W +: pba_pkg::BYTES_W];
            got.free_bytes = m_tdata[pba_pkg::ADDR_W + pba_pkg::BYTES_W +: pba_pkg::BYTES_W];
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: status %0d", got.status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.alloc_addr !== want.alloc_addr)
                begin
                    $error("alloc_addr: expected 0x%06h, got 0x%06h",
                           want.alloc_addr, got.alloc_addr);
                    fail_count++;
                end
                if (got.used_bytes !== want.used_bytes)
                begin
                    $error("used_bytes: expected %0d, got %0d",
                           want.used_bytes, got.used_bytes);
                    fail_count++;
                end
                if (got.free_bytes !== want.free_bytes)
                begin
                    $error("free_bytes: expected %0d, got %0d",
                           want.free_bytes, got.free_bytes);
                    fail_count++;
                end
                if (m_tdata[pba_pkg::M_TDATA_W-1 -: pba_pkg::M_PAD_W] !== '0)
                begin
                    $error("pad: expected 0, got 0x%0h",
                           m_tdata[pba_pkg::M_TDATA_W-1 -: pba_pkg::M_PAD_W]);
                    fail_count++;
                end
            end
        end
        // stall pattern is redrawn at random when its hold count runs out
        if (rcv_left == 0)
        begin
            rcv_mode = rcv_mode_t'($urandom_range(0, 2));
            rcv_left = $urandom_range(16, 160);
        end
        else
            rcv_left--;
        case (rcv_mode)
            RCV_OPEN:   m_tready <= 1'b1;
            RCV_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= (rcv_left % 11) >= 4;
        endcase
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timed out after %0d cycles", cycle_count);
        $display("testbench failed");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        foreach (shadow_map[k])
            shadow_map[k] = '0;
        shadow_used = '0;
        fail_count  = 0;
        burst_left  = 0;
        n_alloc     = 0;
        n_free      = 0;
        n_oom       = 0;
        n_double    = 0;
        peak_pages  = 0;
        rcv_mode    = RCV_OPEN;
        rcv_left    = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < 23; i++)
            send_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].addr,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        // random traffic, allocate heavy so the pool grows
        repeat (300) issue_random_request(55, 35);

        // free at both ends of the pool and in between, then allocate again
        send_request(pba_pkg::MODE_FREE, 24'hFFFFFF, 1'b0, NO_RES);
        send_request(pba_pkg::MODE_FREE, 24'hFFF000, 1'b0, NO_RES);
        send_request(pba_pkg::MODE_FREE, 24'h000FFF, 1'b0, NO_RES);
        repeat (4) issue_random_request(0, 100);
        repeat (7) send_request(pba_pkg::MODE_ALLOC, pba_pkg::ADDR_W'($urandom), 1'b0, NO_RES);

        // balanced random traffic
        repeat (160) issue_random_request(45, 45);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d allocate, %0d free): %0d out of memory, %0d double free",
                 n_alloc + n_free, n_alloc, n_free, n_oom, n_double);
        $display("Peak pool use %0d of %0d pages, %0d mismatches", peak_pages, POOL_PAGES,
                 fail_count);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
